/* sv/smt_pkg.sv */
`timescale 1ns / 1ps

package smt_pkg;

  typedef enum logic [3:0] {
    ST_TOP         = 4'd0,
    ST_TAG_NAME    = 4'd1,
    ST_TAG_NAMED   = 4'd2,
    ST_ATTR        = 4'd3,
    ST_ATTR_NAME   = 4'd4,
    ST_ATTR_NAMED  = 4'd5,
    ST_ATTR_VAL    = 4'd6,
    ST_ATTR_VALUED = 4'd7,
    ST_NESTED      = 4'd8,
    ST_DATA        = 4'd9,
    ST_PARSED      = 4'd10
  } scan_state_t;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_TAG_CHAR    = 4'd1,
    EV_TAG_END     = 4'd2,
    EV_ANAME_CHAR  = 4'd3,
    EV_AVAL_CHAR   = 4'd4,
    EV_ATTR_COMMIT = 4'd5,
    EV_TEXT_CHAR   = 4'd6,
    EV_TEXT_COMMIT = 4'd7,
    EV_CLOSE       = 4'd8,
    EV_DONE        = 4'd9,
    EV_NUL         = 4'd10,
    EV_HALTED      = 4'd11,
    EV_AFTER_DONE  = 4'd12,
    EV_OVERFLOW    = 4'd13
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
  } scan_res_t;

  localparam logic [7:0] NUL_LIMIT_RESET = 8'd50;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

/* sv/smt_scan.sv */
`timescale 1ns / 1ps

module smt_scan import smt_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      in_byte,
  input  logic [7:0]      nul_limit,
  output scan_res_t       res,
  output logic [DW-1:0]   depth_next
);

  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
  localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

  scan_state_t   scan_state, scan_state_next;
  logic          in_token, in_token_next;
  logic          escape_pending, escape_pending_next;
  logic          text_nonempty, text_nonempty_next;
  logic [DW-1:0] nest_depth;
  logic [7:0]    nul_count, nul_count_next;
  logic          halted, halted_next;
  logic          tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_TOP;
      in_token       <= 1'b0;
      escape_pending <= 1'b0;
      text_nonempty  <= 1'b0;
      nest_depth     <= '0;
      nul_count      <= '0;
      halted         <= 1'b0;
    end else if (take) begin
      scan_state     <= scan_state_next;
      in_token       <= in_token_next;
      escape_pending <= escape_pending_next;
      text_nonempty  <= text_nonempty_next;
      nest_depth     <= depth_next;
      nul_count      <= nul_count_next;
      halted         <= halted_next;
    end
  end

  always_comb begin
    scan_state_next     = scan_state;
    in_token_next       = in_token;
    escape_pending_next = escape_pending;
    text_nonempty_next  = text_nonempty;
    depth_next          = nest_depth;
    nul_count_next      = nul_count;
    halted_next         = halted;
    res.ev              = EV_NONE;
    res.ch              = '0;
    tok                 = in_token || !is_ws(in_byte);

    if (halted) begin
      res.ev = EV_HALTED;
    end else if (in_byte == CH_NUL) begin
      if (nul_count >= nul_limit) begin
        halted_next = 1'b1;
        res.ev      = EV_HALTED;
      end else begin
        nul_count_next = nul_count + 8'd1;
        res.ev         = EV_NUL;
      end
    end else begin
      case (scan_state)
        ST_TOP: begin
          if (in_byte == CH_OPEN) scan_state_next = ST_TAG_NAME;
          else if (in_byte == CH_CLOSE) scan_state_next = ST_PARSED;
        end
        ST_TAG_NAME: begin
          in_token_next = tok;
          if (tok) begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              res.ev = EV_TAG_CHAR;
              res.ch = in_byte;
            end else if (in_byte == CH_BSLASH) begin
              escape_pending_next = 1'b1;
            end else if (!is_ws(in_byte)) begin
              res.ev = EV_TAG_CHAR;
              res.ch = in_byte;
            end else begin
              in_token_next   = 1'b0;
              scan_state_next = ST_TAG_NAMED;
              if (nest_depth >= DEPTH_MAX) begin
                depth_next = DEPTH_MAX;
                res.ev     = EV_OVERFLOW;
              end else begin
                depth_next = nest_depth + DEPTH_ONE;
                res.ev     = EV_TAG_END;
              end
            end
          end
        end
        ST_TAG_NAMED: begin
          if (in_byte == CH_N) scan_state_next = ST_NESTED;
          else if (in_byte == CH_OPEN) scan_state_next = ST_ATTR;
        end
        ST_ATTR: begin
          if (in_byte == CH_OPEN) scan_state_next = ST_ATTR_NAME;
          else if (in_byte == CH_CLOSE) scan_state_next = ST_NESTED;
        end
        ST_ATTR_NAME: begin
          in_token_next = tok;
          if (tok) begin
            if (!is_ws(in_byte)) begin
              res.ev = EV_ANAME_CHAR;
              res.ch = in_byte;
            end else begin
              in_token_next   = 1'b0;
              scan_state_next = ST_ATTR_NAMED;
            end
          end
        end
        ST_ATTR_NAMED: begin
          if (in_byte == CH_DOT) scan_state_next = ST_ATTR_VAL;
        end
        ST_ATTR_VAL: begin
          if (!in_token && in_byte == CH_QUOTE) begin
            in_token_next = 1'b1;
          end else if (in_token) begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              res.ev = EV_AVAL_CHAR;
              res.ch = in_byte;
            end else if (in_byte == CH_BSLASH) begin
              escape_pending_next = 1'b1;
            end else if (in_byte != CH_QUOTE) begin
              res.ev = EV_AVAL_CHAR;
              res.ch = in_byte;
            end else begin
              in_token_next   = 1'b0;
              scan_state_next = ST_ATTR_VALUED;
              res.ev          = EV_ATTR_COMMIT;
            end
          end
        end
        ST_ATTR_VALUED: begin
          if (in_byte == CH_CLOSE) scan_state_next = ST_ATTR;
        end
        ST_NESTED: begin
          if (in_byte == CH_OPEN) begin
            scan_state_next = ST_TAG_NAME;
          end else if (in_byte == CH_QUOTE) begin
            scan_state_next    = ST_DATA;
            text_nonempty_next = 1'b0;
          end else if (in_byte == CH_CLOSE) begin
            if (nest_depth <= DEPTH_ONE) begin
              depth_next      = '0;
              scan_state_next = ST_PARSED;
              res.ev          = EV_DONE;
            end else begin
              depth_next = nest_depth - DEPTH_ONE;
              res.ev     = EV_CLOSE;
            end
          end
        end
        ST_DATA: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            text_nonempty_next  = 1'b1;
            res.ev = EV_TEXT_CHAR;
            res.ch = (in_byte == CH_N) ? CH_LF : in_byte;
          end else if (in_byte == CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end else if (in_byte != CH_QUOTE) begin
            text_nonempty_next = 1'b1;
            res.ev = EV_TEXT_CHAR;
            res.ch = in_byte;
          end else begin
            // closing quote: empty text commits nothing
            if (text_nonempty) res.ev = EV_TEXT_COMMIT;
            text_nonempty_next = 1'b0;
            scan_state_next    = ST_NESTED;
          end
        end
        default: begin
          res.ev = EV_AFTER_DONE;
        end
      endcase
    end
  end

endmodule

/* sv/smt_out_reg.sv */
`timescale 1ns / 1ps

module smt_out_reg import smt_pkg::*; #(
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  scan_res_t     res,
  input  logic [DW-1:0] depth,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          free,
  output logic [3:0]    event_res,
  output logic [7:0]    out_char,
  output logic [DW-1:0] node_depth
);

  scan_res_t     res_q;
  logic [DW-1:0] depth_q;

  // slot frees up in the same cycle the held item is taken
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q   <= res;
      depth_q <= depth;
    end
  end

  assign event_res  = res_q.ev;
  assign out_char   = res_q.ch;
  assign node_depth = depth_q;

endmodule

/* sv/sexp_markup_tokenizer.sv */
`timescale 1ns / 1ps
// channel   signals                                  direction
// in        in_valid, in_ready, in_byte              byte items into the scanner
// out       out_valid, out_ready, event_res,
//           out_char, node_depth                     one result item per byte
// cfg       cfg_we, cfg_data                         nul_limit, write only
//
// one byte per cycle while the output is not stalled; each item's result is
// computed combinationally and registered, appearing the cycle after acceptance.
// a new byte is taken whenever the result register is empty or being emptied.
// rst is synchronous: scanner at top level, counters clear, nul_limit back to 50.
// a stalled output holds its item and back-pressures in_ready.

module sexp_markup_tokenizer import smt_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    event_res,
  output logic [7:0]    out_char,
  output logic [DW-1:0] node_depth,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data
);

  logic [7:0]    nul_limit_q;
  logic          take;
  scan_res_t     res;
  logic [DW-1:0] depth_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      nul_limit_q <= NUL_LIMIT_RESET;
    end else if (cfg_we) begin
      nul_limit_q <= cfg_data;
    end
  end

  assign take = in_valid && in_ready;

  smt_scan #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (in_byte),
    .nul_limit  (nul_limit_q),
    .res        (res),
    .depth_next (depth_next)
  );

  smt_out_reg #(.DW(DW)) u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .res        (res),
    .depth      (depth_next),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .free       (in_ready),
    .event_res  (event_res),
    .out_char   (out_char),
    .node_depth (node_depth)
  );

endmodule

/* dv/scan_checker.sv */
`timescale 1ns / 1ps

module scan_checker import smt_pkg::*; #(
  parameter int MAX_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  event_res,
  input  logic [7:0]  out_char,
  input  logic [6:0]  node_depth,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          waiting,
  output int          checked,
  output logic [13:0] seen_events
);

  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic [6:0] depth;
  } token_t;

  token_t expected_tokens[$];

  // scanner copy kept alongside the block
  scan_state_t st;
  logic        tok;
  logic        esc;
  logic        text_any;
  logic        stopped;
  logic [6:0]  depth;
  logic [7:0]  nul_seen;
  logic [7:0]  nul_limit;

  int          mismatches = 0;
  int          results = 0;
  logic [13:0] ev_mask = '0;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic scan_byte(input logic [7:0] c, output token_t r);
    r.ev = EV_NONE;
    r.ch = 8'h00;
    if (stopped) begin
      r.ev = EV_HALTED;
    end else if (c == CH_NUL) begin
      if (nul_seen >= nul_limit) begin
        stopped = 1'b1;
        r.ev = EV_HALTED;
      end else begin
        nul_seen = nul_seen + 8'd1;
        r.ev = EV_NUL;
      end
    end else begin
      case (st)
        ST_TOP: begin
          if (c == CH_OPEN) st = ST_TAG_NAME;
          else if (c == CH_CLOSE) st = ST_PARSED;
        end
        ST_TAG_NAME: begin
          if (!tok && !is_blank(c)) tok = 1'b1;
          if (tok) begin
            if (esc) begin
              esc = 1'b0;
              r.ev = EV_TAG_CHAR;
              r.ch = c;
            end else if (c == CH_BSLASH) begin
              esc = 1'b1;
            end else if (!is_blank(c)) begin
              r.ev = EV_TAG_CHAR;
              r.ch = c;
            end else begin
              tok = 1'b0;
              st = ST_TAG_NAMED;
              // depth saturates, scanning carries on
              if (depth >= MAX_DEPTH) begin
                depth = 7'(MAX_DEPTH);
                r.ev = EV_OVERFLOW;
              end else begin
                depth = depth + 7'd1;
                r.ev = EV_TAG_END;
              end
            end
          end
        end
        ST_TAG_NAMED: begin
          if (c == CH_N) st = ST_NESTED;
          else if (c == CH_OPEN) st = ST_ATTR;
        end
        ST_ATTR: begin
          if (c == CH_OPEN) st = ST_ATTR_NAME;
          else if (c == CH_CLOSE) st = ST_NESTED;
        end
        ST_ATTR_NAME: begin
          if (!tok && !is_blank(c)) tok = 1'b1;
          if (tok) begin
            if (!is_blank(c)) begin
              r.ev = EV_ANAME_CHAR;
              r.ch = c;
            end else begin
              tok = 1'b0;
              st = ST_ATTR_NAMED;
            end
          end
        end
        ST_ATTR_NAMED: begin
          if (c == CH_DOT) st = ST_ATTR_VAL;
        end
        ST_ATTR_VAL: begin
          if (!tok && c == CH_QUOTE) begin
            tok = 1'b1;
          end else if (tok) begin
            if (esc) begin
              esc = 1'b0;
              r.ev = EV_AVAL_CHAR;
              r.ch = c;
            end else if (c == CH_BSLASH) begin
              esc = 1'b1;
            end else if (c != CH_QUOTE) begin
              r.ev = EV_AVAL_CHAR;
              r.ch = c;
            end else begin
              tok = 1'b0;
              st = ST_ATTR_VALUED;
              r.ev = EV_ATTR_COMMIT;
            end
          end
        end
        ST_ATTR_VALUED: begin
          if (c == CH_CLOSE) st = ST_ATTR;
        end
        ST_NESTED: begin
          if (c == CH_OPEN) begin
            st = ST_TAG_NAME;
          end else if (c == CH_QUOTE) begin
            st = ST_DATA;
            text_any = 1'b0;
          end else if (c == CH_CLOSE) begin
            if (depth <= 7'd1) begin
              depth = 7'd0;
              st = ST_PARSED;
              r.ev = EV_DONE;
            end else begin
              depth = depth - 7'd1;
              r.ev = EV_CLOSE;
            end
          end
        end
        ST_DATA: begin
          if (esc) begin
            esc = 1'b0;
            text_any = 1'b1;
            r.ev = EV_TEXT_CHAR;
            r.ch = (c == CH_N) ? CH_LF : c;
          end else if (c == CH_BSLASH) begin
            esc = 1'b1;
          end else if (c != CH_QUOTE) begin
            text_any = 1'b1;
            r.ev = EV_TEXT_CHAR;
            r.ch = c;
          end else begin
            // empty text commits nothing
            if (text_any) r.ev = EV_TEXT_COMMIT;
            text_any = 1'b0;
            st = ST_NESTED;
          end
        end
        default: r.ev = EV_AFTER_DONE;
      endcase
    end
    r.depth = depth;
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      st = ST_TOP;
      tok = 1'b0;
      esc = 1'b0;
      text_any = 1'b0;
      stopped = 1'b0;
      depth = 7'd0;
      nul_seen = 8'd0;
      nul_limit = NUL_LIMIT_RESET;
      expected_tokens.delete();
    end else begin
      // retire results before taking the new item
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("result item with nothing expected", event_res, -1);
        end else begin
          want = expected_tokens.pop_front();
          results++;
          ev_mask[want.ev] = 1'b1;
          if (event_res !== want.ev)
            report_mismatch($sformatf("event_res (want %s)", want.ev.name()),
                            event_res, want.ev);
          if (out_char !== want.ch)
            report_mismatch("out_char", out_char, want.ch);
          if (node_depth !== want.depth)
            report_mismatch("node_depth", node_depth, want.depth);
        end
      end
      if (cfg_we) nul_limit = cfg_data;
      if (in_valid && in_ready) begin
        scan_byte(in_byte, want);
        expected_tokens.push_back(want);
      end
    end
    fail_count  <= mismatches;
    waiting     <= expected_tokens.size();
    checked     <= results;
    seen_events <= ev_mask;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import smt_pkg::*;

  localparam int MAX_DEPTH   = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_res;
  logic [7:0]  out_char;
  logic [6:0]  node_depth;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  int          fail_count;
  int          waiting;
  int          checked;
  logic [13:0] seen_events;

  int          send_idle_pct = 29;
  int          recv_idle_pct = 70;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          nul_sent = 0;
  int          open_elems = 0;
  bit          nul_noise = 1'b0;
  logic [7:0]  nul_budget = NUL_LIMIT_RESET;
  logic [7:0]  halt_limit;
  logic [7:0]  script_q[$];

  always #5 clk = ~clk;

  sexp_markup_tokenizer #(.MAX_DEPTH(MAX_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .out_char(out_char), .node_depth(node_depth),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  scan_checker #(.MAX_DEPTH(MAX_DEPTH)) u_scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .out_char(out_char), .node_depth(node_depth),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .waiting(waiting), .checked(checked),
    .seen_events(seen_events)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(5) == 0) ? CH_SPACE : 8'($urandom_range(13, 9));
  endfunction

  // bytes the scanner ignores in every structural state
  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while (c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE || c == CH_BSLASH ||
           c == CH_DOT || c == CH_N);
    return c;
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while (c == CH_BSLASH || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
    return c;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while (c == CH_BSLASH || c == CH_QUOTE);
    return c;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) script_q.push_back(s[i]);
  endtask

  task automatic push_unit(input logic [7:0] c);
    if ($urandom_range(5) == 0) begin
      script_q.push_back(CH_BSLASH);
      script_q.push_back(8'($urandom_range(255, 1)));
    end else begin
      script_q.push_back(c);
    end
  endtask

  task automatic push_attrs();
    script_q.push_back(CH_OPEN);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(3) == 0) script_q.push_back(filler_byte());
      script_q.push_back(CH_OPEN);
      if ($urandom_range(3) == 0) script_q.push_back(blank_byte());
      repeat ($urandom_range(3, 1)) script_q.push_back(name_byte());
      script_q.push_back(blank_byte());
      if ($urandom_range(3) == 0) script_q.push_back(filler_byte());
      script_q.push_back(CH_DOT);
      if ($urandom_range(3) == 0) script_q.push_back(filler_byte());
      script_q.push_back(CH_QUOTE);
      repeat ($urandom_range(4)) push_unit(text_byte());
      script_q.push_back(CH_QUOTE);
      if ($urandom_range(3) == 0) script_q.push_back(filler_byte());
      script_q.push_back(CH_CLOSE);
    end
    script_q.push_back(CH_CLOSE);
  endtask

  task automatic push_element_head(input bit attrs_ok);
    script_q.push_back(CH_OPEN);
    if ($urandom_range(3) == 0) script_q.push_back(blank_byte());
    repeat ($urandom_range(4, 1)) push_unit(name_byte());
    script_q.push_back(blank_byte());
    if ($urandom_range(4) == 0) script_q.push_back(filler_byte());
    if (!attrs_ok || $urandom_range(1) == 0) push_str("nil");
    else push_attrs();
    open_elems++;
  endtask

  task automatic push_text();
    script_q.push_back(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(4) == 0) begin
        script_q.push_back(CH_BSLASH);
        script_q.push_back($urandom_range(1) ? CH_N : 8'($urandom_range(255, 1)));
      end else begin
        script_q.push_back(text_byte());
      end
    end
    script_q.push_back(CH_QUOTE);
  endtask

  // element bodies; the root is never closed here
  task automatic grow_document(input int target);
    int pick;
    while (script_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 30 && open_elems < 6) begin
        push_element_head(1'b1);
      end else if (pick < 60) begin
        push_text();
      end else if (pick < 70) begin
        repeat ($urandom_range(2, 1)) script_q.push_back(filler_byte());
      end else if (open_elems > 1) begin
        script_q.push_back(CH_CLOSE);
        open_elems--;
      end else begin
        push_element_head(1'b1);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (b == CH_NUL) nul_sent++;
  endtask

  task automatic play_script();
    while (script_q.size() != 0) begin
      // stray nuls, kept under the current limit
      if (nul_noise && nul_sent < nul_budget && $urandom_range(99) < 3)
        send_byte(CH_NUL);
      send_byte(script_q.pop_front());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_nul_limit(input logic [7:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    nul_budget = value;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // top-level junk, a nul, escaped tag chars, an attribute with an escaped
    // quote, empty and escaped text, then a child element opened and closed
    script_q.push_back(CH_SPACE);
    script_q.push_back(8'hff);
    script_q.push_back(CH_NUL);
    push_str("(\\ ");
    script_q.push_back(8'h80);
    push_str("\t((k .\"\\\"\"))\"\"\"\\nx\"(c n)");
    play_script();
    open_elems = 1;

    write_nul_limit(8'd0);
    nul_noise = 1'b1;
    grow_document(400);
    play_script();

    send_idle_pct = 70;
    recv_idle_pct = 29;
    write_nul_limit(8'd255);
    grow_document(400);
    play_script();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_nul_limit(8'd100);
    grow_document(300);
    // nest past the depth limit, then close everything and beyond
    while (open_elems < MAX_DEPTH + 2) push_element_head(1'b0);
    repeat (open_elems + 1) script_q.push_back(CH_CLOSE);
    open_elems = 0;
    repeat (4) script_q.push_back(8'($urandom_range(255, 1)));
    play_script();
    if (nul_sent < nul_budget) send_byte(CH_NUL);

    // limit equal to the count so far: the next nul halts
    nul_noise  = 1'b0;
    halt_limit = 8'(nul_sent);
    write_nul_limit(halt_limit);
    script_q.push_back(CH_NUL);
    script_q.push_back(CH_OPEN);
    script_q.push_back(8'($urandom_range(255, 1)));
    script_q.push_back(CH_NUL);
    play_script();

    drain();
    repeat (4) @(posedge clk);
    $display("sent %0d bytes (%0d nul) and checked %0d results; nul_limit 50, 0, 255, 100, %0d",
             bytes_sent, nul_sent, checked, halt_limit);
    $display("event codes seen, bit per code 13 down to 0: %b", seen_events);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
